// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion held off while reset is active
`define TFN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tfn assertion failed");

// concurrent assertion that is also checked during reset
`define TFN_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tfn assertion failed");

`endif

// ===== hdl/tfn_pkg.sv =====
// shared widths and item types of the triangle face normal pipeline
package tfn_pkg;

  localparam int CW = 24;
  localparam int F = 14;
  localparam int NW = 16;
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int CMW = 2 * CW + 1;
  localparam int SQLO = (CMW + 1) / 2;
  localparam int SQHI = CMW - SQLO;
  localparam int SQW = 2 * CMW;
  localparam int SW = 2 * CMW + 2;
  localparam int XW = SW + 2 * F + 6;
  localparam int QW = F + 1;
  localparam int VW = (QW + 1 > NW) ? QW + 1 : NW;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CMW-1:0] cmag_t;
  typedef logic [SQW-1:0] sq_t;
  typedef logic signed [XW-1:0] wide_t;
  typedef logic [QW-1:0] qv_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
    logic last;
  } tri_t;

  typedef struct packed {
    cmag_t [2:0] mag;
    logic [2:0] neg;
    logic last;
  } cross_t;

  typedef struct packed {
    wide_t e;
    wide_t g;
    qv_t q;
    logic neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;
    wide_t s;
    logic degen;
    logic last;
  } root_t;

endpackage

// ===== hdl/tfn_cross.sv =====
// edge vectors and exact cross product, three register stages
module tfn_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  tfn_pkg::tri_t   in_tri,
  output logic            out_valid,
  output tfn_pkg::cross_t out_cross
);

  logic signed [tfn_pkg::EW-1:0] edge_r [6];
  logic signed [tfn_pkg::EW-1:0] edge_nxt [6];
  logic signed [tfn_pkg::PW-1:0] pa_r [3];
  logic signed [tfn_pkg::PW-1:0] pb_r [3];
  logic signed [tfn_pkg::PW-1:0] pa_nxt [3];
  logic signed [tfn_pkg::PW-1:0] pb_nxt [3];
  tfn_pkg::cross_t cross_r, cross_nxt;
  logic [2:0] valid_r;
  logic [1:0] last_r;

  // edges v = b - a and w = c - a
  always_comb begin
    edge_nxt[0] = tfn_pkg::EW'(in_tri.b.x) - tfn_pkg::EW'(in_tri.a.x);
    edge_nxt[1] = tfn_pkg::EW'(in_tri.b.y) - tfn_pkg::EW'(in_tri.a.y);
    edge_nxt[2] = tfn_pkg::EW'(in_tri.b.z) - tfn_pkg::EW'(in_tri.a.z);
    edge_nxt[3] = tfn_pkg::EW'(in_tri.c.x) - tfn_pkg::EW'(in_tri.a.x);
    edge_nxt[4] = tfn_pkg::EW'(in_tri.c.y) - tfn_pkg::EW'(in_tri.a.y);
    edge_nxt[5] = tfn_pkg::EW'(in_tri.c.z) - tfn_pkg::EW'(in_tri.a.z);
  end

  // the six products of the cross product
  always_comb begin
    pa_nxt[0] = tfn_pkg::PW'(edge_r[1]) * tfn_pkg::PW'(edge_r[5]);
    pb_nxt[0] = tfn_pkg::PW'(edge_r[2]) * tfn_pkg::PW'(edge_r[4]);
    pa_nxt[1] = tfn_pkg::PW'(edge_r[2]) * tfn_pkg::PW'(edge_r[3]);
    pb_nxt[1] = tfn_pkg::PW'(edge_r[0]) * tfn_pkg::PW'(edge_r[5]);
    pa_nxt[2] = tfn_pkg::PW'(edge_r[0]) * tfn_pkg::PW'(edge_r[4]);
    pb_nxt[2] = tfn_pkg::PW'(edge_r[1]) * tfn_pkg::PW'(edge_r[3]);
  end

  // differences split into sign and magnitude
  always_comb begin
    logic signed [tfn_pkg::PW:0] diff;
    logic [tfn_pkg::PW:0] absd;
    cross_nxt.last = last_r[1];
    for (int k = 0; k < 3; k++) begin
      diff = (tfn_pkg::PW + 1)'(pa_r[k]) - (tfn_pkg::PW + 1)'(pb_r[k]);
      absd = diff[tfn_pkg::PW] ? -diff : diff;
      cross_nxt.neg[k] = diff[tfn_pkg::PW];
      cross_nxt.mag[k] = absd[tfn_pkg::CMW-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      edge_r <= edge_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      cross_r <= cross_nxt;
      last_r <= {last_r[0], in_tri.last};
    end
  end

  assign out_valid = valid_r[2];
  assign out_cross = cross_r;

endmodule

// ===== hdl/tfn_norm.sv =====
// squared length of the cross product and start values of the root search
module tfn_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  tfn_pkg::cross_t in_cross,
  output logic            out_valid,
  output tfn_pkg::root_t  out_root
);

  localparam int HHW = 2 * tfn_pkg::SQHI;
  localparam int HLW = tfn_pkg::SQHI + tfn_pkg::SQLO;
  localparam int LLW = 2 * tfn_pkg::SQLO;

  logic [HHW-1:0] hh_r [3], hh_nxt [3];
  logic [HLW-1:0] hl_r [3], hl_nxt [3];
  logic [LLW-1:0] ll_r [3], ll_nxt [3];
  tfn_pkg::sq_t sq1_r [3], sq2_r [3], sq_nxt [3];
  logic [tfn_pkg::SW-1:0] s_r, s_nxt;
  logic [2:0] neg1_r, neg2_r, neg3_r;
  logic [2:0] degen_r, last_r;
  logic degen_nxt;
  tfn_pkg::root_t root_r, root_nxt;
  logic [3:0] valid_r;

  // partial products of each square
  always_comb begin
    logic [tfn_pkg::SQHI-1:0] hi;
    logic [tfn_pkg::SQLO-1:0] lo;
    for (int k = 0; k < 3; k++) begin
      hi = in_cross.mag[k][tfn_pkg::CMW-1:tfn_pkg::SQLO];
      lo = in_cross.mag[k][tfn_pkg::SQLO-1:0];
      hh_nxt[k] = HHW'(hi) * HHW'(hi);
      hl_nxt[k] = HLW'(hi) * HLW'(lo);
      ll_nxt[k] = LLW'(lo) * LLW'(lo);
    end
    degen_nxt = (in_cross.mag[0] == '0) && (in_cross.mag[1] == '0) &&
                (in_cross.mag[2] == '0);
  end

  // squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = (tfn_pkg::SQW'(hh_r[k]) << (2 * tfn_pkg::SQLO)) +
                  (tfn_pkg::SQW'(hl_r[k]) << (tfn_pkg::SQLO + 1)) +
                  tfn_pkg::SQW'(ll_r[k]);
    end
  end

  // sum of squares
  assign s_nxt = tfn_pkg::SW'(sq1_r[0]) + tfn_pkg::SW'(sq1_r[1]) +
                 tfn_pkg::SW'(sq1_r[2]);

  // residual e = c^2 4^(F+1) - s and g = -s for the odd candidate -1
  always_comb begin
    tfn_pkg::wide_t sw;
    sw = $signed(tfn_pkg::XW'(s_r));
    root_nxt.s = sw;
    root_nxt.degen = degen_r[2];
    root_nxt.last = last_r[2];
    for (int k = 0; k < 3; k++) begin
      root_nxt.lane[k].e = ($signed(tfn_pkg::XW'(sq2_r[k])) <<< (2 * tfn_pkg::F + 2)) - sw;
      root_nxt.lane[k].g = -sw;
      root_nxt.lane[k].q = '0;
      root_nxt.lane[k].neg = neg3_r[k];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      ll_r <= ll_nxt;
      sq1_r <= sq_nxt;
      sq2_r <= sq1_r;
      s_r <= s_nxt;
      root_r <= root_nxt;
      neg1_r <= in_cross.neg;
      neg2_r <= neg1_r;
      neg3_r <= neg2_r;
      degen_r <= {degen_r[1:0], degen_nxt};
      last_r <= {last_r[1:0], in_cross.last};
    end
  end

  assign out_valid = valid_r[3];
  assign out_root = root_r;

endmodule

// ===== hdl/tfn_root.sv =====
// one stage per result bit: restoring search of round(|c| 2^F / sqrt(s))
module tfn_root (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tfn_pkg::root_t in_root,
  output logic           out_valid,
  output tfn_pkg::root_t out_root
);

  tfn_pkg::root_t stage_r [tfn_pkg::QW];
  tfn_pkg::root_t stage_nxt [tfn_pkg::QW];
  logic [tfn_pkg::QW-1:0] valid_r;

  for (genvar k = 0; k < tfn_pkg::QW; k++) begin : g_bit
    localparam int B = tfn_pkg::F - k;
    tfn_pkg::root_t cur;

    if (k == 0) begin : g_first
      assign cur = in_root;
    end else begin : g_next
      assign cur = stage_r[k-1];
    end

    // try setting bit B: odd candidate grows by 2^(B+1)
    always_comb begin
      tfn_pkg::wide_t delta;
      tfn_pkg::wide_t ediff;
      logic take;
      stage_nxt[k] = cur;
      for (int l = 0; l < 3; l++) begin
        delta = (cur.lane[l].g <<< (B + 2)) + (cur.s <<< (2 * B + 2));
        ediff = cur.lane[l].e - delta;
        take = !ediff[tfn_pkg::XW-1];
        if (take) begin
          stage_nxt[k].lane[l].e = ediff;
          stage_nxt[k].lane[l].g = cur.lane[l].g + (cur.s <<< (B + 1));
        end
        stage_nxt[k].lane[l].q[B] = take;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[tfn_pkg::QW-2:0], in_valid};
    end
  end

  assign out_valid = valid_r[tfn_pkg::QW-1];
  assign out_root = stage_r[tfn_pkg::QW-1];

endmodule

// ===== hdl/triangle_face_normal.sv =====
// top level of the triangle face normal pipeline
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata: 9 coordinates, tlast: last_in
//  out_     master     out_tvalid/out_tready tdata: normal x,y,z, tuser: degenerate,
//                                           tlast: last_out
//
// one item per cycle while the output is not stalled; an item passes through the
// cross product, the squared length, the per-bit root search (one stage per result
// bit) and the output register.
// rst_n clears every valid bit; payload registers are not reset.
// when the output register holds an item that is not taken, the whole pipeline
// holds and in_tready is low.
module triangle_face_normal (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [215:0] in_tdata,   // first_x, first_y, first_z, second_x, second_y,
                                   // second_z, third_x, third_y, third_z
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // normal_x, normal_y, normal_z
  output logic         out_tuser,  // degenerate
  output logic         out_tlast
);

  localparam int CW = tfn_pkg::CW;
  localparam int NW = tfn_pkg::NW;

  logic en;
  tfn_pkg::tri_t tri_in;
  logic cross_valid, norm_valid, root_valid;
  tfn_pkg::cross_t cross_item;
  tfn_pkg::root_t norm_item, root_item;
  logic out_valid_r;
  logic [3*NW-1:0] data_r, data_nxt;
  logic degen_r, last_r;

  // whole pipeline advances unless the output item is stalled
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  // unpack the input item
  assign tri_in.a.x = in_tdata[0*CW +: CW];
  assign tri_in.a.y = in_tdata[1*CW +: CW];
  assign tri_in.a.z = in_tdata[2*CW +: CW];
  assign tri_in.b.x = in_tdata[3*CW +: CW];
  assign tri_in.b.y = in_tdata[4*CW +: CW];
  assign tri_in.b.z = in_tdata[5*CW +: CW];
  assign tri_in.c.x = in_tdata[6*CW +: CW];
  assign tri_in.c.y = in_tdata[7*CW +: CW];
  assign tri_in.c.z = in_tdata[8*CW +: CW];
  assign tri_in.last = in_tlast;

  tfn_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_tri    (tri_in),
    .out_valid (cross_valid),
    .out_cross (cross_item)
  );

  tfn_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cross_valid),
    .in_cross  (cross_item),
    .out_valid (norm_valid),
    .out_root  (norm_item)
  );

  tfn_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (norm_valid),
    .in_root   (norm_item),
    .out_valid (root_valid),
    .out_root  (root_item)
  );

  // apply signs, zero the degenerate case
  always_comb begin
    logic [tfn_pkg::VW-1:0] v;
    for (int k = 0; k < 3; k++) begin
      v = tfn_pkg::VW'(root_item.lane[k].q);
      if (root_item.lane[k].neg) begin
        v = -v;
      end
      if (root_item.degen) begin
        v = '0;
      end
      data_nxt[k*NW +: NW] = v[NW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      degen_r <= root_item.degen;
      last_r <= root_item.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = data_r;
  assign out_tuser = degen_r;
  assign out_tlast = last_r;

endmodule

// ===== hdl/tfn_checker.sv =====
// port-level checks of the triangle face normal block and their bind
`include "assert_macros.svh"

module tfn_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic         out_tuser
);

  logic in_range;

  // every component within unit length
  assign in_range = ($signed(out_tdata[15:0]) <= 16'sd16384) &&
                    ($signed(out_tdata[15:0]) >= -16'sd16384) &&
                    ($signed(out_tdata[31:16]) <= 16'sd16384) &&
                    ($signed(out_tdata[31:16]) >= -16'sd16384) &&
                    ($signed(out_tdata[47:32]) <= 16'sd16384) &&
                    ($signed(out_tdata[47:32]) >= -16'sd16384);

  // a stalled result item stays offered
  `TFN_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)

  // the pipeline takes items whenever the sink takes them
  `TFN_ASSERT_NR(a_ready_follows, clk, out_tready |-> in_tready)

  // reset leaves no result item offered
  `TFN_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_tvalid)

  // a degenerate item carries a zero normal
  `TFN_ASSERT(a_degen_zero, clk, rst_n, out_tvalid && out_tuser |-> out_tdata == 48'd0)

  // components stay within unit length
  `TFN_ASSERT(a_unit_range, clk, rst_n, out_tvalid |-> in_range)

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/triangle_face_normal_tb.sv =====
// self-checking testbench for the triangle face normal pipeline
module triangle_face_normal_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 700;
  localparam int N_CALM = 100;  // final items sent with no input gaps and no new output stall bursts

  typedef struct packed {
    logic [tfn_pkg::NW-1:0] nx;
    logic [tfn_pkg::NW-1:0] ny;
    logic [tfn_pkg::NW-1:0] nz;
    logic          degen;
    logic          last;
  } normal_t;

  // directed rows: coordinates a, b, c; known marks a result typed in by hand
  typedef struct {
    int     co[9];
    bit     last;
    bit     known;
    int     nx;
    int     ny;
    int     nz;
    bit     degen;
  } row_t;

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;

  row_t face_rows[] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, 1, 0, 0, 0, 1},
    '{'{0, 0, 0, 256, 0, 0, 0, 256, 0}, 0, 1, 0, 0, 16384, 0},
    '{'{0, 0, 0, 0, 256, 0, 0, 0, 256}, 1, 1, 16384, 0, 0, 0},
    '{'{0, 0, 0, 0, 0, 256, 256, 0, 0}, 0, 1, 0, 16384, 0, 0},
    '{'{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1, 1, 0, 0, -16384, 0},
    '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 0, 1, 0, 0, 0, 1},
    '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1, 1, 0, 0, 0, 1},
    '{'{0, 0, 0, 1, 1, 1, 2, 2, 2}, 0, 1, 0, 0, 0, 1},
    '{'{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}, 0, 0, 0, 0, 0, 0},
    '{'{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN}, 1, 0, 0, 0, 0, 0},
    '{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}, 0, 0, 0, 0, 0, 0},
    '{'{0, 0, 0, 1, -1, 0, 1, 0, -1}, 0, 0, 0, 0, 0, 0},
    '{'{5592405, 5592405, 5592405, -5592406, 5592405, -5592406,
        5592405, -5592406, -5592406}, 1, 0, 0, 0, 0, 0},
    '{'{7, -3, 100, 7, -3, 100, 9, 11, -4}, 0, 1, 0, 0, 0, 1},
    '{'{0, 0, 0, 3, 0, 0, 0, 4, 0}, 0, 0, 0, 0, 0, 0}
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [215:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  normal_t      normals_due[$];
  int           err_cnt;
  bit           calm;
  int           stall_left;

  triangle_face_normal u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // exact unit normal: rounded |n| 2^F / sqrt(s) by a bitwise search on squares
  function automatic normal_t face_normal(logic [215:0] tdata, logic last);
    normal_t     r;
    longint      p[9];
    longint      v[3];
    longint      w[3];
    longint      n[3];
    logic [255:0] m[3];
    logic [255:0] s;
    logic [255:0] tgt;
    logic [255:0] odd;
    logic [255:0] cand;
    logic [255:0] q;
    logic [tfn_pkg::NW-1:0] o[3];
    for (int i = 0; i < 9; i++)
      p[i] = longint'(tfn_pkg::coord_t'(tdata[i*tfn_pkg::CW +: tfn_pkg::CW]));
    for (int i = 0; i < 3; i++) begin
      v[i] = p[3+i] - p[i];
      w[i] = p[6+i] - p[i];
    end
    n[0] = v[1] * w[2] - v[2] * w[1];
    n[1] = v[2] * w[0] - v[0] * w[2];
    n[2] = v[0] * w[1] - v[1] * w[0];
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (n[i] < 0) ? 256'(-n[i]) : 256'(n[i]);
      s = s + m[i] * m[i];
    end
    r.last = last;
    r.degen = (s == 0);
    for (int i = 0; i < 3; i++) begin
      q = '0;
      if (s != 0) begin
        tgt = (m[i] * m[i]) << (2 * tfn_pkg::F + 2);
        for (int b = tfn_pkg::F; b >= 0; b--) begin
          cand = q | (256'd1 << b);
          odd = 2 * cand - 1;
          if (s * odd * odd <= tgt) q = cand;
        end
      end
      o[i] = (n[i] < 0) ? tfn_pkg::NW'(-q) : tfn_pkg::NW'(q);
    end
    r.nx = o[0];
    r.ny = o[1];
    r.nz = o[2];
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    err_cnt++;
  endtask

  // send one triangle, waiting out backpressure; the expectation goes in on acceptance
  task automatic send_triangle(logic [215:0] d, logic last, bit known, normal_t want);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    normals_due.push_back(known ? want : face_normal(d, last));
  endtask

  // result side: random stall bursts, compare each taken item against the oldest
  always @(posedge clk) begin
    normal_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (normals_due.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = normals_due.pop_front();
          if (out_tdata[15:0] !== want.nx)
            report_mismatch("normal_x", int'($signed(out_tdata[15:0])),
                            int'($signed(want.nx)));
          if (out_tdata[31:16] !== want.ny)
            report_mismatch("normal_y", int'($signed(out_tdata[31:16])),
                            int'($signed(want.ny)));
          if (out_tdata[47:32] !== want.nz)
            report_mismatch("normal_z", int'($signed(out_tdata[47:32])),
                            int'($signed(want.nz)));
          if (out_tuser !== want.degen)
            report_mismatch("degenerate", int'(out_tuser), int'(want.degen));
          if (out_tlast !== want.last)
            report_mismatch("last", int'(out_tlast), int'(want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 16);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [215:0] d;
    normal_t      want;
    int           kind;
    int           k;
    int           lim;
    err_cnt   = 0;
    calm      = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (face_rows[i]) begin
      for (int j = 0; j < 9; j++)
        d[j*tfn_pkg::CW +: tfn_pkg::CW] = face_rows[i].co[j][tfn_pkg::CW-1:0];
      want.nx = tfn_pkg::NW'(face_rows[i].nx);
      want.ny = tfn_pkg::NW'(face_rows[i].ny);
      want.nz = tfn_pkg::NW'(face_rows[i].nz);
      want.degen = face_rows[i].degen;
      want.last = face_rows[i].last;
      send_triangle(d, face_rows[i].last, face_rows[i].known, want);
    end

    // random triangles: full range, small meshes, and collinear ones
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) calm = 1;
      kind = $urandom_range(0, 9);
      for (int j = 0; j < 9; j++) d[j*tfn_pkg::CW +: tfn_pkg::CW] = tfn_pkg::CW'($urandom);
      if (kind >= 4) begin
        lim = (kind >= 8) ? 8 : 4096;
        for (int j = 3; j < 9; j++)
          d[j*tfn_pkg::CW +: tfn_pkg::CW] = d[(j%3)*tfn_pkg::CW +: tfn_pkg::CW]
              + tfn_pkg::CW'($urandom_range(0, 2*lim) - lim);
      end
      if (kind == 3) begin
        // third vertex on the line through the first two
        k = $urandom_range(0, 6) - 3;
        for (int j = 0; j < 3; j++) begin
          d[(3+j)*tfn_pkg::CW +: tfn_pkg::CW] = d[j*tfn_pkg::CW +: tfn_pkg::CW]
              + tfn_pkg::CW'($urandom_range(0, 2000) - 1000);
          d[(6+j)*tfn_pkg::CW +: tfn_pkg::CW] = d[j*tfn_pkg::CW +: tfn_pkg::CW]
              + tfn_pkg::CW'(k * (d[(3+j)*tfn_pkg::CW +: tfn_pkg::CW]
                                  - d[j*tfn_pkg::CW +: tfn_pkg::CW]));
        end
      end
      send_triangle(d, 1'($urandom_range(0, 1)), 0, want);
    end
    in_tvalid <= 1'b0;

    while (normals_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[triangle_face_normal] OK");
    end else begin
      $display("[triangle_face_normal] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[triangle_face_normal] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tfn_pkg.sv
hdl/tfn_cross.sv
hdl/tfn_norm.sv
hdl/tfn_root.sv
hdl/triangle_face_normal.sv
hdl/tfn_checker.sv
tb/triangle_face_normal_tb.sv
